// ===== hdl/chte_pkg.sv =====
`default_nettype none
package chte_pkg;

	localparam int XY_SHIFT = 16;
	localparam int X_GUARD = 3;
	localparam int ANG_FRAC = 8;
	localparam int TAB_LEN = 20;
	localparam int ZW = 23;
	localparam int TH_W = 14;
	localparam int ANG_W = 16;

	localparam int CORDIC_STAGES_DEF = 14;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam logic [ANG_W-1:0] FULL_TURN = 16'd36000;
	localparam logic [ANG_W-1:0] HALF_TURN = 16'd18000;
	localparam logic [ANG_W-1:0] QUARTER_TURN = 16'd9000;
	localparam logic [ANG_W-1:0] THREE_QUARTER_TURN = 16'd27000;

	localparam logic [2:0] DEADBAND_RESET = 3'd0;
	localparam logic [14:0] DEADBAND_DEF = 15'd2000;

	// register indexes on the configuration port
	typedef enum logic {
		REG_TARGET = 1'b0,
		REG_DEADBAND = 1'b1
	} reg_idx_t;

	// side-band flags that travel with each sample
	typedef struct packed {
		logic neg_a;
		logic neg_b;
		logic zero_a;
		logic zero_b;
	} meta_t;

	// atan(2^-i) in hundredths of a degree times 256
	function automatic logic signed [ZW-1:0] atan_val(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0: v = 23'sd1152000;
			1: v = 23'sd680065;
			2: v = 23'sd359328;
			3: v = 23'sd182400;
			4: v = 23'sd91554;
			5: v = 23'sd45822;
			6: v = 23'sd22916;
			7: v = 23'sd11459;
			8: v = 23'sd5730;
			9: v = 23'sd2865;
			10: v = 23'sd1432;
			11: v = 23'sd716;
			12: v = 23'sd358;
			13: v = 23'sd179;
			14: v = 23'sd90;
			15: v = 23'sd45;
			16: v = 23'sd22;
			17: v = 23'sd11;
			18: v = 23'sd6;
			19: v = 23'sd3;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/chte_front.sv =====
`default_nettype none
module chte_front
	import chte_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire signed [SAMPLE_BITS-1:0] comp_a,
	input  wire signed [SAMPLE_BITS-1:0] comp_b,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [SAMPLE_BITS:0]         mag_a,
	output logic [SAMPLE_BITS:0]         mag_b,
	output meta_t                        meta
);

	logic                   valid_s1;
	logic [SAMPLE_BITS:0]   ma_s1, mb_s1;
	meta_t                  meta_s1;
	logic [SAMPLE_BITS:0]   na, nb;

	// negate one bit wider so the most negative sample folds to its magnitude
	assign na = comp_a[SAMPLE_BITS-1] ? -{comp_a[SAMPLE_BITS-1], comp_a}
		: {1'b0, comp_a};
	assign nb = comp_b[SAMPLE_BITS-1] ? -{comp_b[SAMPLE_BITS-1], comp_b}
		: {1'b0, comp_b};

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ma_s1 <= na;
			mb_s1 <= nb;
			meta_s1.neg_a <= comp_a[SAMPLE_BITS-1];
			meta_s1.neg_b <= comp_b[SAMPLE_BITS-1];
			meta_s1.zero_a <= (comp_a == '0);
			meta_s1.zero_b <= (comp_b == '0);
		end
	end

	assign out_valid = valid_s1;
	assign mag_a = ma_s1;
	assign mag_b = mb_s1;
	assign meta = meta_s1;

endmodule
`default_nettype wire

// ===== hdl/chte_cordic_stage.sv =====
`default_nettype none
module chte_cordic_stage
	import chte_pkg::*;
#(
	parameter int XW = SAMPLE_BITS_DEF + XY_SHIFT + X_GUARD,
	parameter int IDX = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire signed [XW-1:0] in_x,
	input  wire signed [XW-1:0] in_y,
	input  wire signed [ZW-1:0] in_z,
	input  meta_t               in_meta,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic signed [XW-1:0] out_x,
	output logic signed [XW-1:0] out_y,
	output logic signed [ZW-1:0] out_z,
	output meta_t               out_meta
);

	localparam logic signed [ZW-1:0] ANG = atan_val(IDX);

	logic                 valid_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	meta_t                meta_s1;
	logic signed [XW-1:0] dx, dy;

	// arithmetic shift is the floor of the division
	assign dx = in_y >>> IDX;
	assign dy = in_x >>> IDX;

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			meta_s1 <= in_meta;
			if (!in_y[XW-1]) begin
				x_s1 <= in_x + dx;
				y_s1 <= in_y - dy;
				z_s1 <= in_z + ANG;
			end else begin
				x_s1 <= in_x - dx;
				y_s1 <= in_y + dy;
				z_s1 <= in_z - ANG;
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_x = x_s1;
	assign out_y = y_s1;
	assign out_z = z_s1;
	assign out_meta = meta_s1;

endmodule
`default_nettype wire

// ===== hdl/chte_back.sv =====
`default_nettype none
module chte_back
	import chte_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire signed [ZW-1:0]    in_z,
	input  meta_t                  in_meta,
	input  wire [ANG_W-1:0]        target,
	input  wire [14:0]             deadband,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [ANG_W-1:0]       heading,
	output logic [ANG_W-1:0]       reverse_heading,
	output logic signed [ANG_W-1:0] turn_error,
	output logic signed [ANG_W-1:0] turn_quantized
);

	logic v1, v2, v3, v4;
	logic r1, r2, r3, r4;

	// stage 1: round and clamp the first quadrant angle
	logic [TH_W-1:0]      th_s1;
	meta_t                meta_s1;
	logic signed [ZW-1:0] zr;
	logic [TH_W-1:0]      th_c;

	// stage 2: place in quadrant
	logic [ANG_W-1:0] h_s2;
	logic [ANG_W:0]   h_raw;
	logic [ANG_W:0]   th_x;

	// stage 3: reverse heading and wrapped error
	logic [ANG_W-1:0]        h_s3, rev_s3;
	logic signed [ANG_W-1:0] err_s3;
	logic signed [ANG_W+1:0] diff;
	logic signed [ANG_W+1:0] diff_w;
	logic [ANG_W:0]          rev_raw;

	// stage 4: deadband
	logic [ANG_W-1:0]        h_s4, rev_s4;
	logic signed [ANG_W-1:0] err_s4, q_s4;
	logic [ANG_W-1:0]        mag;

	assign r4 = !v4 || out_ready;
	assign r3 = !v3 || r4;
	assign r2 = !v2 || r3;
	assign r1 = !v1 || r2;
	assign in_ready = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
		end else begin
			if (r1) v1 <= in_valid;
			if (r2) v2 <= v1;
			if (r3) v3 <= v2;
			if (r4) v4 <= v3;
		end
	end

	assign zr = (in_z + ZW'(1 << (ANG_FRAC - 1))) >>> ANG_FRAC;

	always_comb begin
		if (zr[ZW-1] || in_meta.zero_b) begin
			th_c = '0;
		end else if (zr > $signed({{(ZW-ANG_W){1'b0}}, QUARTER_TURN})) begin
			th_c = TH_W'(QUARTER_TURN);
		end else begin
			th_c = zr[TH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && in_valid) begin
			th_s1 <= th_c;
			meta_s1 <= in_meta;
		end
	end

	assign th_x = {{(ANG_W+1-TH_W){1'b0}}, th_s1};

	always_comb begin
		if (meta_s1.zero_a && meta_s1.zero_b) begin
			h_raw = '0;
		end else if (meta_s1.zero_a) begin
			h_raw = meta_s1.neg_b ? {1'b0, THREE_QUARTER_TURN} : {1'b0, QUARTER_TURN};
		end else if (!meta_s1.neg_a) begin
			h_raw = meta_s1.neg_b ? {1'b0, FULL_TURN} - th_x : th_x;
		end else begin
			h_raw = meta_s1.neg_b ? {1'b0, HALF_TURN} + th_x : {1'b0, HALF_TURN} - th_x;
		end
	end

	always_ff @(posedge clk) begin
		if (r2 && v1) begin
			h_s2 <= (h_raw >= {1'b0, FULL_TURN}) ? ANG_W'(h_raw - {1'b0, FULL_TURN})
				: h_raw[ANG_W-1:0];
		end
	end

	assign diff = $signed({2'b00, h_s2}) - $signed({2'b00, target});
	assign rev_raw = {1'b0, h_s2} + {1'b0, HALF_TURN};

	always_comb begin
		if (diff > $signed({2'b00, HALF_TURN})) begin
			diff_w = diff - $signed({2'b00, FULL_TURN});
		end else if (diff < -$signed({2'b00, HALF_TURN})) begin
			diff_w = diff + $signed({2'b00, FULL_TURN});
		end else begin
			diff_w = diff;
		end
	end

	always_ff @(posedge clk) begin
		if (r3 && v2) begin
			h_s3 <= h_s2;
			rev_s3 <= (rev_raw >= {1'b0, FULL_TURN}) ? ANG_W'(rev_raw - {1'b0, FULL_TURN})
				: rev_raw[ANG_W-1:0];
			err_s3 <= diff_w[ANG_W-1:0];
		end
	end

	assign mag = err_s3[ANG_W-1] ? ANG_W'(-err_s3) : ANG_W'(err_s3);

	always_ff @(posedge clk) begin
		if (r4 && v3) begin
			h_s4 <= h_s3;
			rev_s4 <= rev_s3;
			err_s4 <= err_s3;
			q_s4 <= (mag < {1'b0, deadband}) ? '0 : err_s3;
		end
	end

	assign out_valid = v4;
	assign heading = h_s4;
	assign reverse_heading = rev_s4;
	assign turn_error = err_s4;
	assign turn_quantized = q_s4;

endmodule
`default_nettype wire

// ===== hdl/compass_heading_turn_error.sv =====
// compass heading and turn error from a two-axis field sample
//
// input channel: in_valid / in_stall carry one transfer of (comp_a, comp_b).
// a transfer happens at a rising edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall carry heading, reverse_heading,
// turn_error and turn_quantized, one result transfer per input transfer.
// configuration: apb-style port, target_heading at 0x0, deadband at 0x4;
// write only while no sample is in flight. pready is always high.
// pipeline: one magnitude stage, one stage per cordic iteration (14 by
// default), then round, quadrant, wrap and deadband stages.
// throughput: one sample per cycle while out_stall is low, set by the
// fully unrolled cordic pipe.
// each stage holds its own valid bit and advances when the stage after it
// is empty or moving, so bubbles close up under a stalled receiver.
// when the receiver stalls, the result holds on the ports and the pipe
// keeps accepting until every stage is full, then in_stall rises.
// reset empties the pipe, target_heading goes to 0, deadband to 2000.
`default_nettype none
module compass_heading_turn_error
	import chte_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// sample channel
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire signed [SAMPLE_BITS-1:0] comp_a,
	input  wire signed [SAMPLE_BITS-1:0] comp_b,
	// result channel
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [15:0]                  heading,
	output logic [15:0]                  reverse_heading,
	output logic signed [15:0]           turn_error,
	output logic signed [15:0]           turn_quantized,
	// configuration port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [2:0]                    paddr,
	input  wire [31:0]                   pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	// cordic datapath width: magnitude, fraction shift and growth guard
	localparam int XW = SAMPLE_BITS + XY_SHIFT + X_GUARD;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [15:0] target_q;
	logic [15:0] tgt_q;      // target reduced below a full turn
	logic [14:0] deadband_q;
	logic        wr_en;
	reg_idx_t    wr_idx;
	logic [15:0] wr_tgt;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign wr_idx = reg_idx_t'(paddr[2]);
	assign wr_tgt = pwdata[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			tgt_q <= '0;
			deadband_q <= DEADBAND_DEF;
		end else if (wr_en) begin
			case (wr_idx)
				REG_TARGET: begin
					target_q <= wr_tgt;
					tgt_q <= (wr_tgt >= FULL_TURN) ? wr_tgt - FULL_TURN : wr_tgt;
				end
				REG_DEADBAND: begin
					deadband_q <= pwdata[14:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_TARGET:   prdata = {16'd0, target_q};
			REG_DEADBAND: prdata = {17'd0, deadband_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// magnitude stage
	// ---------------------------------------------------------------
	logic                   f_valid, f_ready;
	logic [SAMPLE_BITS:0]   f_ma, f_mb;
	meta_t                  f_meta;
	logic                   front_ready;

	chte_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (front_ready),
		.comp_a   (comp_a),
		.comp_b   (comp_b),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.mag_a    (f_ma),
		.mag_b    (f_mb),
		.meta     (f_meta)
	);

	assign in_stall = !front_ready;

	// ---------------------------------------------------------------
	// cordic vectoring pipe, one iteration per stage
	// ---------------------------------------------------------------
	logic                 c_valid [CORDIC_STAGES+1];
	logic                 c_ready [CORDIC_STAGES+1];
	logic signed [XW-1:0] c_x     [CORDIC_STAGES+1];
	logic signed [XW-1:0] c_y     [CORDIC_STAGES+1];
	logic signed [ZW-1:0] c_z     [CORDIC_STAGES+1];
	meta_t                c_meta  [CORDIC_STAGES+1];

	// magnitudes are one bit wider than a sample, the guard takes the rest
	assign c_valid[0] = f_valid;
	assign f_ready = c_ready[0];
	assign c_x[0] = {{(X_GUARD-1){1'b0}}, f_ma, {XY_SHIFT{1'b0}}};
	assign c_y[0] = {{(X_GUARD-1){1'b0}}, f_mb, {XY_SHIFT{1'b0}}};
	assign c_z[0] = '0;
	assign c_meta[0] = f_meta;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		chte_cordic_stage #(
			.XW (XW),
			.IDX(g)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (c_valid[g]),
			.in_ready (c_ready[g]),
			.in_x     (c_x[g]),
			.in_y     (c_y[g]),
			.in_z     (c_z[g]),
			.in_meta  (c_meta[g]),
			.out_valid(c_valid[g+1]),
			.out_ready(c_ready[g+1]),
			.out_x    (c_x[g+1]),
			.out_y    (c_y[g+1]),
			.out_z    (c_z[g+1]),
			.out_meta (c_meta[g+1])
		);
	end

	// ---------------------------------------------------------------
	// rounding, quadrant, wrap and deadband stages
	// ---------------------------------------------------------------
	chte_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (c_valid[CORDIC_STAGES]),
		.in_ready       (c_ready[CORDIC_STAGES]),
		.in_z           (c_z[CORDIC_STAGES]),
		.in_meta        (c_meta[CORDIC_STAGES]),
		.target         (tgt_q),
		.deadband       (deadband_q),
		.out_valid      (out_valid),
		.out_ready      (!out_stall),
		.heading        (heading),
		.reverse_heading(reverse_heading),
		.turn_error     (turn_error),
		.turn_quantized (turn_quantized)
	);

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// a receiver that is not blocking means every stage can move
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled while the result side drains");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading < FULL_TURN))
		else $error("heading out of range");

	a_reverse_rel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((heading < HALF_TURN && reverse_heading == heading + HALF_TURN)
			|| (heading >= HALF_TURN && reverse_heading == heading - HALF_TURN)))
		else $error("reverse heading does not match heading");

	a_quant_rel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (turn_quantized == '0 || turn_quantized == turn_error))
		else $error("quantized error is neither zero nor the error");

endmodule
`default_nettype wire
